@@ rtl/sis_pkg.sv @@
// sis_pkg: shared types and constants for the stack insertion sorter.
// Used by sis_ctrl, sis_datapath and stack_insertion_sorter; no dependencies.
package sis_pkg;

  localparam int KEY_W = 32;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;   // place the incoming key into the store
    logic shift;    // drop the head entry, everything moves one place down
    logic clear;    // batch finished: empty the store and the overflow flag
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_one; // exactly one key left in the store
  } dp_stat_t;

endpackage

@@ rtl/sis_datapath.sv @@
// sis_datapath: compare-and-shift register array holding the batch, largest at entry 0,
// plus the fill count and overflow flag. Depends on sis_pkg.
module sis_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sis_pkg::dp_cmd_t                 cmd,
  input  logic signed [sis_pkg::KEY_W-1:0] key,
  output sis_pkg::dp_stat_t                stat,
  output logic signed [sis_pkg::KEY_W-1:0] head_key,
  output logic                             overflow
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [sis_pkg::KEY_W-1:0] store_r [DEPTH];
  logic signed [sis_pkg::KEY_W-1:0] store_nxt [DEPTH];
  logic [CW-1:0] fill_r, fill_nxt;
  logic          overflow_r, overflow_nxt;
  logic [DEPTH-1:0] sh;
  logic          full;

  assign full = (fill_r == CW'(DEPTH));

  // entries not greater than the new key move down; new key goes above equal ones
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sh[i] = (CW'(i) < fill_r) && (store_r[i] <= key);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    fill_nxt     = fill_r;
    overflow_nxt = overflow_r;
    if (cmd.insert) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i > 0 && sh[(i > 0) ? i - 1 : 0]) begin
            store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
          end else if (sh[i] || CW'(i) == fill_r) begin
            store_nxt[i] = key;
          end
        end
        fill_nxt = fill_r + CW'(1);
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        store_nxt[i] = store_r[i + 1];
      end
      fill_nxt = fill_r - CW'(1);
    end
    if (cmd.clear) begin
      fill_nxt     = '0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      overflow_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  assign head_key      = store_r[0];
  assign overflow      = overflow_r;
  assign stat.last_one = (fill_r == CW'(1));

  fill_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond store depth");

  full_insert_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && full |=> overflow_r && fill_r == $past(fill_r))
    else $error("key stored into a full store");

  clear_a: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> fill_r == '0 && !overflow_r)
    else $error("store not emptied at batch end");

endmodule

@@ rtl/sis_ctrl.sv @@
// sis_ctrl: batch controller, accepts keys and sequences emission of the sorted batch.
// Depends on sis_pkg.
module sis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               batch_end,
  input  sis_pkg::dp_stat_t  stat,
  output sis_pkg::dp_cmd_t   cmd,
  output logic               busy,
  output logic               emit,
  output logic               final_res
);

  sis_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sis_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b0;
    emit       = 1'b0;
    final_res  = 1'b0;
    unique case (state_r)
      sis_pkg::ST_IDLE: begin
        if (start) begin
          cmd.insert = 1'b1;
          if (batch_end) begin
            state_nxt = sis_pkg::ST_EMIT;
          end
        end
      end
      sis_pkg::ST_EMIT: begin
        busy      = 1'b1;
        emit      = 1'b1;
        cmd.shift = 1'b1;
        final_res = stat.last_one;
        if (stat.last_one) begin
          cmd.clear = 1'b1;
          state_nxt = sis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sis_pkg::ST_IDLE;
      end
    endcase
  end

  no_insert_busy_a: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.insert)
    else $error("request taken while emitting");

  last_to_idle_a: assert property (@(posedge clk) disable iff (!rst_n)
    emit && final_res |=> state_r == sis_pkg::ST_IDLE)
    else $error("emission did not stop after final key");

  end_to_emit_a: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && batch_end |=> emit)
    else $error("batch end did not start emission");

endmodule

@@ rtl/stack_insertion_sorter.sv @@
// stack_insertion_sorter: top level, sorts a batch of signed keys, largest emitted first.
// Depends on sis_pkg, sis_ctrl and sis_datapath.
// Latency: a key is inserted in the cycle of its request (one request per cycle while idle).
// The request carrying batch_end is followed, from the next cycle, by one result per stored
// key on consecutive cycles (N results for N stored keys, N <= DEPTH); busy is high throughout.
// Results cannot be stalled. Synchronous active-low reset empties the store and flags.
module stack_insertion_sorter #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sis_pkg::KEY_W-1:0] in_key,
  input  logic                             in_batch_end,
  output logic                             out_valid,
  output logic signed [sis_pkg::KEY_W-1:0] out_sorted_key,
  output logic                             out_final_res,
  output logic                             out_dropped
);

  sis_pkg::dp_cmd_t  cmd;
  sis_pkg::dp_stat_t stat;
  logic              overflow;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .batch_end (in_batch_end),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .emit      (out_valid),
    .final_res (out_final_res)
  );

  sis_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .key      (in_key),
    .stat     (stat),
    .head_key (out_sorted_key),
    .overflow (overflow)
  );

  assign out_dropped = out_valid & overflow;

  run_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> out_valid && out_dropped == $past(out_dropped))
    else $error("emission broke off before final key");

  quiet_a: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_batch_end |=> !out_valid)
    else $error("result emitted for an ordinary key");

  final_gap_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result emitted after final key");

endmodule

@@ sim/stack_insertion_sorter_tb.sv @@
// Self-checking testbench for stack_insertion_sorter: directed and random key batches,
// predicted by a sorted-store model in the testbench and checked result by result.
// Depends on sis_pkg and the stack_insertion_sorter RTL.
module stack_insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int KW = sis_pkg::KEY_W;
  localparam int RANDOM_REQS = 360;
  localparam int QUIET_TAIL = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [KW-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KW-1:0] KEY_MIN = 32'sh8000_0000;

  typedef enum int {
    FLAV_WIDE,
    FLAV_NARROW,
    FLAV_EDGE
  } key_flavour_t;

  typedef struct {
    logic signed [KW-1:0] key;
    logic                 batch_end;
    int                   gap;
  } key_req_t;

  typedef struct {
    logic signed [KW-1:0] key;
    logic                 last;
    logic                 dropped;
  } sorted_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [KW-1:0] in_key = '0;
  logic                 in_batch_end = 1'b0;
  logic                 out_valid;
  logic signed [KW-1:0] out_sorted_key;
  logic                 out_final_res;
  logic                 out_dropped;

  key_req_t    pending_reqs[$];
  sorted_res_t awaited_keys[$];
  key_req_t    cur_req;
  int          gap_left = 0;

  // sorted store mirror: ascending from entry 0
  logic signed [KW-1:0] mirror_store[DEPTH];
  int                   mirror_fill = 0;
  logic                 mirror_overflow = 1'b0;

  int errors = 0;
  int reqs_accepted = 0;
  int batches_closed = 0;
  int overflow_batches = 0;
  int results_checked = 0;
  int cycle_count = 0;

  stack_insertion_sorter #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_key        (in_key),
    .in_batch_end  (in_batch_end),
    .out_valid     (out_valid),
    .out_sorted_key(out_sorted_key),
    .out_final_res (out_final_res),
    .out_dropped   (out_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Insert one key into the mirror; on batch end, queue the whole batch largest first.
  function automatic void sort_insert(input logic signed [KW-1:0] k, input logic last);
    int pos;
    sorted_res_t res;
    if (mirror_fill >= DEPTH) begin
      mirror_overflow = 1'b1;
    end else begin
      pos = mirror_fill;
      // equal keys stay below the newcomer
      while (pos > 0 && mirror_store[pos-1] > k) begin
        mirror_store[pos] = mirror_store[pos-1];
        pos--;
      end
      mirror_store[pos] = k;
      mirror_fill++;
    end
    if (last) begin
      for (int i = mirror_fill - 1; i >= 0; i--) begin
        res.key = mirror_store[i];
        res.last = (i == 0);
        res.dropped = mirror_overflow;
        awaited_keys.push_back(res);
      end
      batches_closed++;
      if (mirror_overflow) overflow_batches++;
      mirror_fill = 0;
      mirror_overflow = 1'b0;
    end
  endfunction

  function automatic logic signed [KW-1:0] draw_key(input key_flavour_t flav);
    logic signed [KW-1:0] edges[7];
    edges = '{KEY_MIN, KEY_MIN + 1, -1, 0, 1, KEY_MAX - 1, KEY_MAX};
    case (flav)
      FLAV_NARROW: return $signed(KW'($urandom_range(0, 8))) - 4;
      FLAV_EDGE:   return edges[$urandom_range(0, 6)];
      default:     return $signed($urandom);
    endcase
  endfunction

  task automatic add_req(input logic signed [KW-1:0] k, input logic last, input int gap);
    key_req_t r;
    r.key = k;
    r.batch_end = last;
    r.gap = gap;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int n;
    int batch_len;
    int sel;
    bit gappy;
    key_flavour_t flav;
    // single-key batches at both extremes, idle while the first one drains
    add_req(KEY_MAX, 1'b1, 3);
    add_req(KEY_MIN, 1'b1, 0);
    // mixed signs with a duplicate as the closing key
    add_req(0, 1'b0, 0);
    add_req(KEY_MIN, 1'b0, 0);
    add_req(-1, 1'b0, 0);
    add_req(KEY_MAX, 1'b0, 1);
    add_req(1, 1'b0, 0);
    add_req(1, 1'b1, 2);
    // fill the store exactly, then a closing key that no longer fits
    for (int i = 0; i < DEPTH; i++) begin
      add_req((i % 2) ? -(i * 7) : i * 13, 1'b0, 0);
    end
    add_req(5, 1'b1, 0);

    n = 0;
    while (n < RANDOM_REQS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) batch_len = $urandom_range(DEPTH + 1, DEPTH + 6);
      else if (sel == 1) batch_len = DEPTH;
      else batch_len = $urandom_range(1, 12);
      flav = key_flavour_t'($urandom_range(0, 2));
      gappy = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < batch_len; i++) begin
        add_req(draw_key(flav), i == batch_len - 1,
                (gappy && n < RANDOM_REQS - QUIET_TAIL && $urandom_range(0, 2) == 0) ?
                $urandom_range(1, 9) : 0);
        n++;
      end
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        sort_insert(in_key, in_batch_end);
        reqs_accepted++;
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        start <= 1'b1;
        in_key <= cur_req.key;
        in_batch_end <= cur_req.batch_end;
        gap_left = cur_req.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sorted_res_t exp_res;
    if (rst_n && out_valid) begin
      if (awaited_keys.size() == 0) begin
        flag_error($sformatf("unexpected result key %0d", out_sorted_key));
      end else begin
        exp_res = awaited_keys.pop_front();
        results_checked++;
        if (out_sorted_key !== exp_res.key)
          flag_error($sformatf("sorted_key %0d, expected %0d", out_sorted_key, exp_res.key));
        if (out_final_res !== exp_res.last)
          flag_error($sformatf("final_res %b, expected %b (key %0d)", out_final_res,
                               exp_res.last, exp_res.key));
        if (out_dropped !== exp_res.dropped)
          flag_error($sformatf("dropped %b, expected %b (key %0d)", out_dropped,
                               exp_res.dropped, exp_res.key));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("stack_insertion_sorter verification failed");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (awaited_keys.size() != 0) @(posedge clk);
    // catch any stray results after the last batch
    repeat (DEPTH + 4) @(posedge clk);
    if (mirror_fill != 0)
      flag_error($sformatf("%0d keys still held in an unclosed batch", mirror_fill));
    $display("%0d requests in %0d batches (%0d overflowed), %0d sorted results checked",
             reqs_accepted, batches_closed, overflow_batches, results_checked);
    if (errors == 0) begin
      $display("stack_insertion_sorter verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("stack_insertion_sorter verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sis_pkg.sv
rtl/sis_datapath.sv
rtl/sis_ctrl.sv
rtl/stack_insertion_sorter.sv
sim/stack_insertion_sorter_tb.sv
